// ===== rtl/ipl_pkg.sv =====
// ipl_pkg: shared sizes, codes and word types for the indexed position list
// used by ipl_cell, ipl_pick_tree and indexed_position_list; no dependencies
package ipl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;
  localparam int GROUP    = 8;
  localparam int NGRP     = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_POP    = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        [2:0]  action;
    logic        [6:0]  position_index;
    logic signed [15:0] in_row;
    logic signed [15:0] in_col;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_row;
    logic signed [15:0] out_col;
    logic        [6:0]  entry_count;
    logic        [1:0]  status;
  } result_t;

  typedef struct packed {
    logic signed [15:0] row;
    logic signed [15:0] col;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             exec;
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] at;
    logic             pick_en;
    logic [IDX_W-1:0] pick_at;
    entry_t           data;
  } cell_ctrl_t;

endpackage

// ===== rtl/ipl_cell.sv =====
// ipl_cell: one list slot, shifts with its neighbours on insert or remove
// depends on ipl_pkg
module ipl_cell (
  input  logic                      clk,
  input  ipl_pkg::cell_ctrl_t       ctrl,
  input  logic [ipl_pkg::IDX_W-1:0] pos,
  input  ipl_pkg::entry_t           prev,
  input  ipl_pkg::entry_t           next,
  output ipl_pkg::entry_t           entry,
  output ipl_pkg::entry_t           pick,
  output logic                      hit
);
  import ipl_pkg::*;

  entry_t entry_next;

  always_comb begin
    entry_next = entry;
    priority if (ctrl.ins && (pos > ctrl.at)) begin
      entry_next = prev;
    end else if (ctrl.ins && (pos == ctrl.at)) begin
      entry_next = ctrl.data;
    end else if (ctrl.rem && (pos >= ctrl.at)) begin
      entry_next = next;
    end else begin
      entry_next = entry;
    end
  end

  assign hit = ctrl.pick_en && (pos == ctrl.pick_at);

  // pick holds the old value, so a removed entry is still seen
  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (ctrl.exec) begin
      pick <= hit ? entry : '0;
    end
  end

endmodule

// ===== rtl/ipl_pick_tree.sv =====
// ipl_pick_tree: two-level or-tree gathering the picked entry, first level registered
// depends on ipl_pkg
module ipl_pick_tree (
  input  logic            clk,
  input  logic            load,
  input  ipl_pkg::entry_t picks [ipl_pkg::CAPACITY],
  output ipl_pkg::entry_t total
);
  import ipl_pkg::*;

  entry_t grp      [NGRP];
  entry_t grp_next [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          grp_next[g] = grp_next[g] | picks[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_next;
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total | grp[g];
    end
  end

endmodule

// ===== rtl/indexed_position_list.sv =====
// indexed_position_list: ordered list of row/column entries held in a chain
// of cells; depends on ipl_pkg, ipl_cell and ipl_pick_tree
//
//   word     direction  handshake                    payload
//   item     in         item_valid / item_ready      ipl_pkg::item_t
//   result   out        result_valid / result_ready  ipl_pkg::result_t
//
// one word at a time: accepted, executed in all cells at once the next
// cycle, then the or-tree gathers the entry read or removed, first into
// its group registers, then into the result; a new word is accepted only
// once the result of the last word has been loaded
// reset clears the count; cell contents are not cleared
// a stalled result holds the final stage, the next word may already execute
module indexed_position_list (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  ipl_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output ipl_pkg::result_t result
);
  import ipl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_RED1 = 4'b0100,
    S_RED2 = 4'b1000
  } state_t;

  localparam logic [6:0] CAP_CNT = 7'(CAPACITY);

  state_t           state;
  state_t           state_next;
  item_t            op;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       status_next;
  logic [1:0]       res_status;
  logic [CNT_W-1:0] res_count;
  cell_ctrl_t       ctrl;
  cell_ctrl_t       ctrl_raw;
  entry_t           entries [CAPACITY];
  entry_t           picks   [CAPACITY];
  logic [CAPACITY-1:0] hits;
  entry_t           total;
  logic [CMP_W-1:0] idx_c;
  logic [CMP_W-1:0] cnt_c;
  logic             full;
  logic             res_load;

  assign item_ready = (state == S_IDLE);
  assign idx_c      = CMP_W'(op.position_index);
  assign cnt_c      = CMP_W'(count);
  assign full       = (count == CNT_W'(CAPACITY));
  assign res_load   = (state == S_RED2) && (!result_valid || result_ready);

  always_comb begin
    ctrl_raw      = '0;
    ctrl_raw.data = '{row: op.in_row, col: op.in_col};
    status_next   = ST_OK;
    count_next    = count;
    unique case (op.action)
      ACT_INSERT: begin
        if (idx_c > cnt_c) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl_raw.ins = 1'b1;
          ctrl_raw.at  = IDX_W'(op.position_index);
          count_next   = count + 1'b1;
        end
      end
      ACT_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl_raw.ins = 1'b1;
          ctrl_raw.at  = IDX_W'(count);
          count_next   = count + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (idx_c >= cnt_c) begin
          status_next = ST_RANGE;
        end else begin
          ctrl_raw.rem     = 1'b1;
          ctrl_raw.at      = IDX_W'(op.position_index);
          ctrl_raw.pick_en = 1'b1;
          ctrl_raw.pick_at = IDX_W'(op.position_index);
          count_next       = count - 1'b1;
        end
      end
      ACT_POP: begin
        if (count == '0) begin
          status_next = ST_RANGE;
        end else begin
          ctrl_raw.rem     = 1'b1;
          ctrl_raw.at      = IDX_W'(count - 1'b1);
          ctrl_raw.pick_en = 1'b1;
          ctrl_raw.pick_at = IDX_W'(count - 1'b1);
          count_next       = count - 1'b1;
        end
      end
      ACT_READ: begin
        if (idx_c >= cnt_c) begin
          status_next = ST_RANGE;
        end else begin
          ctrl_raw.pick_en = 1'b1;
          ctrl_raw.pick_at = IDX_W'(op.position_index);
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // cells only move during the execute cycle
  always_comb begin
    ctrl         = ctrl_raw;
    ctrl.exec    = (state == S_EXEC);
    ctrl.ins     = ctrl_raw.ins && ctrl.exec;
    ctrl.rem     = ctrl_raw.rem && ctrl.exec;
    ctrl.pick_en = ctrl_raw.pick_en && ctrl.exec;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ipl_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .pos   (IDX_W'(i)),
      .prev  ((i == 0) ? entries[0] : entries[(i == 0) ? 0 : i - 1]),
      .next  ((i == CAPACITY - 1) ? entries[i] : entries[(i == CAPACITY - 1) ? i : i + 1]),
      .entry (entries[i]),
      .pick  (picks[i]),
      .hit   (hits[i])
    );
  end

  ipl_pick_tree u_tree (
    .clk   (clk),
    .load  (state == S_RED1),
    .picks (picks),
    .total (total)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (item_valid) state_next = S_EXEC;
      S_EXEC: state_next = S_RED1;
      S_RED1: state_next = S_RED2;
      S_RED2: if (res_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        count <= count_next;
      end
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      op <= item;
    end
    if (state == S_EXEC) begin
      res_status <= status_next;
      res_count  <= count_next;
    end
    if (res_load) begin
      result.out_row     <= total.row;
      result.out_col     <= total.col;
      result.entry_count <= 7'(res_count);
      result.status      <= res_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> state == S_EXEC)
    else $error("accepted word not executed next cycle");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hits))
    else $error("more than one cell picked");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_FULL) |-> result.entry_count == CAP_CNT)
    else $error("full status with list not full");

endmodule

// ===== tb/indexed_position_list_tb.sv =====
// indexed_position_list_tb: self-checking bench for the indexed position list,
// with a list predictor, random idle gaps on both sides and a field-by-field check
// depends on ipl_pkg and indexed_position_list
`timescale 1ns / 1ps

module indexed_position_list_tb;
  import ipl_pkg::*;

  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  localparam int MOOD_GROW  = 0;
  localparam int MOOD_MIX   = 1;
  localparam int MOOD_DRAIN = 2;
  localparam int MOOD_NOISE = 3;

  localparam int WORD_TARGET = 530;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  indexed_position_list u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  item_t   words_to_send[$];
  result_t results_due[$];
  entry_t  held[CAPACITY];
  int      held_count = 0;
  int      plan_count = 0;
  int      words_total = 0;
  int      words_taken = 0;
  int      mismatches = 0;
  int      cycle = 0;
  logic    item_fired = 1'b0;
  logic    result_fired = 1'b0;
  int      send_gap = 0;
  int      sink_hold = 0;
  int      send_calm = 0;
  int      sink_calm = 0;

  // list behaviour: one word in, one result out
  function automatic result_t apply_to_list(item_t w);
    result_t r;
    int      at;
    int      i;
    r = '0;
    case (w.action)
      ACT_INSERT, ACT_APPEND: begin
        at = (w.action == ACT_APPEND) ? held_count : int'(w.position_index);
        if (at > held_count) begin
          r.status = ST_RANGE;
        end else if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = held_count; i > at; i--) held[i] = held[i-1];
          held[at].row = w.in_row;
          held[at].col = w.in_col;
          held_count++;
        end
      end
      ACT_REMOVE, ACT_POP: begin
        at = (w.action == ACT_POP) ? held_count - 1 : int'(w.position_index);
        if (held_count == 0 || at >= held_count) begin
          r.status = ST_RANGE;
        end else begin
          r.out_row = held[at].row;
          r.out_col = held[at].col;
          for (i = at; i + 1 < held_count; i++) held[i] = held[i+1];
          held_count--;
        end
      end
      ACT_READ: begin
        at = int'(w.position_index);
        if (at >= held_count) begin
          r.status = ST_RANGE;
        end else begin
          r.out_row = held[at].row;
          r.out_col = held[at].col;
        end
      end
      ACT_CLEAR: held_count = 0;
      default: ;
    endcase
    r.entry_count = held_count[6:0];
    return r;
  endfunction

  // mostly back-to-back, sometimes a few cycles, now and then a long pause,
  // with quiet stretches of no idling at all
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [15:0] pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'sh8000;
    if (r < 16) return 16'sh7fff;
    if (r < 20) return 16'sh0000;
    if (r < 24) return -16'sd1;
    return 16'($urandom_range(0, 65535));
  endfunction

  // rough list length at generation time, only to steer the indexes
  task automatic queue_word(logic [2:0] act, int idx, logic signed [15:0] row,
                            logic signed [15:0] col);
    item_t w;
    w.action         = act;
    w.position_index = idx[6:0];
    w.in_row         = row;
    w.in_col         = col;
    words_to_send.push_back(w);
    case (act)
      ACT_INSERT: if (idx <= plan_count && plan_count < CAPACITY) plan_count++;
      ACT_APPEND: if (plan_count < CAPACITY) plan_count++;
      ACT_REMOVE: if (idx < plan_count) plan_count--;
      ACT_POP:    if (plan_count > 0) plan_count--;
      ACT_CLEAR:  plan_count = 0;
      default: ;
    endcase
  endtask

  task automatic queue_random(int mood);
    int         r;
    int         idx;
    logic [2:0] act;
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, 127);
    case (mood)
      MOOD_GROW:
        act = (r < 45) ? ACT_APPEND : (r < 90) ? ACT_INSERT : (r < 95) ? ACT_READ : ACT_REMOVE;
      MOOD_DRAIN:
        act = (r < 45) ? ACT_POP : (r < 90) ? ACT_REMOVE : ACT_READ;
      MOOD_MIX:
        act = (r < 20) ? ACT_INSERT : (r < 35) ? ACT_APPEND : (r < 60) ? ACT_READ :
              (r < 75) ? ACT_REMOVE : (r < 90) ? ACT_POP : (r < 97) ? ACT_INSERT : ACT_CLEAR;
      default: act = 3'($urandom_range(0, 7));
    endcase
    // well-formed words mostly land on a live index
    if (mood != MOOD_NOISE && $urandom_range(0, 19) != 0) begin
      if (act == ACT_INSERT) idx = $urandom_range(0, plan_count);
      else if (plan_count > 0) idx = $urandom_range(0, plan_count - 1);
    end
    queue_word(act, idx, pick_coord(), pick_coord());
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // drive on the falling edge
  always @(negedge clk) begin
    if (item_fired) send_gap = pick_gap(send_calm);
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && !item_fired) begin
      // hold the word until taken
    end else if (send_gap > 0) begin
      item_valid <= 1'b0;
      send_gap--;
    end else if (words_to_send.size() > 0) begin
      item       <= words_to_send.pop_front();
      item_valid <= 1'b1;
    end else begin
      item_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (result_fired) sink_hold = pick_gap(sink_calm);
    if (rst) begin
      result_ready <= 1'b0;
    end else if (sink_hold > 0) begin
      result_ready <= 1'b0;
      sink_hold--;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // sample on the rising edge
  always @(posedge clk) begin
    result_t want;
    cycle        <= cycle + 1;
    item_fired   <= !rst && item_valid && item_ready;
    result_fired <= !rst && result_valid && result_ready;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (results_due.size() == 0) begin
          $error("result word with nothing outstanding: %p", result);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("out_row", want.out_row, result.out_row);
          check_field("out_col", want.out_col, result.out_col);
          check_field("entry_count", want.entry_count, result.entry_count);
          check_field("status", want.status, result.status);
        end
      end
      if (item_valid && item_ready) begin
        results_due.push_back(apply_to_list(item));
        words_taken++;
      end
    end
  end

  initial begin
    while (cycle < CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int mood;
    int len;
    // empty list refusals
    queue_word(ACT_READ, 0, 16'sd0, 16'sd0);
    queue_word(ACT_POP, 0, 16'sd0, 16'sd0);
    queue_word(ACT_REMOVE, 0, 16'sd0, 16'sd0);
    queue_word(ACT_INSERT, 1, 16'sd5, 16'sd5);
    queue_word(ACT_INSERT, 127, -16'sd1, -16'sd1);
    // extremes and shifts
    queue_word(ACT_APPEND, 127, 16'sh7fff, 16'sh8000);
    queue_word(ACT_APPEND, 0, 16'sh8000, 16'sh7fff);
    queue_word(ACT_INSERT, 0, 16'sd0, 16'sd0);
    queue_word(ACT_INSERT, 3, -16'sd1, -16'sd1);
    queue_word(ACT_INSERT, 1, 16'sh1234, -16'sh1234);
    queue_word(ACT_READ, 0, 16'sd0, 16'sd0);
    queue_word(ACT_READ, 4, 16'sd0, 16'sd0);
    queue_word(ACT_READ, 5, 16'sd0, 16'sd0);
    queue_word(ACT_READ, 64, 16'sd0, 16'sd0);
    queue_word(ACT_REMOVE, 2, 16'sd0, 16'sd0);
    queue_word(ACT_REMOVE, 64, 16'sd0, 16'sd0);
    queue_word(ACT_POP, 127, 16'sd0, 16'sd0);
    // unknown actions leave the list alone
    queue_word(ACT_SPARE_A, 127, -16'sd1, -16'sd1);
    queue_word(ACT_SPARE_B, 0, 16'sh7fff, 16'sh7fff);
    queue_word(ACT_READ, 1, 16'sd0, 16'sd0);
    queue_word(ACT_CLEAR, 127, 16'sd0, 16'sd0);
    queue_word(ACT_READ, 0, 16'sd0, 16'sd0);
    queue_word(ACT_POP, 0, 16'sd0, 16'sd0);
    queue_word(ACT_APPEND, 0, -16'sd2, 16'sd2);
    // fill toward the top first so that the full refusal is likely to be reached
    repeat (CAPACITY + 6) queue_random(MOOD_GROW);
    while (words_to_send.size() < WORD_TARGET) begin
      len = $urandom_range(0, 9);
      mood = (len < 3) ? MOOD_GROW : (len < 6) ? MOOD_MIX : (len < 8) ? MOOD_DRAIN : MOOD_NOISE;
      len = (mood == MOOD_GROW) ? $urandom_range(10, 80) : $urandom_range(5, 40);
      repeat (len) queue_random(mood);
    end
    words_total = words_to_send.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_taken < words_total || results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ipl_pkg.sv
rtl/ipl_cell.sv
rtl/ipl_pick_tree.sv
rtl/indexed_position_list.sv
tb/indexed_position_list_tb.sv
